/* design/evq_pkg.sv */
`timescale 1ns / 1ps

package evq_pkg;

  // Default ring depth
  localparam int DEPTH_DEF = 16;

  // Width of one stored entry: ref, kind, storage id
  localparam int ENTRY_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_REREAD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] item_ref;
    logic [7:0]  item_kind;
    logic [7:0]  store_id;
  } cmd_t;

  typedef struct packed {
    logic [15:0] out_ref;
    logic [7:0]  out_kind;
    logic [7:0]  out_store_id;
    logic        took_event;
    logic        id_found;
    logic        dropped;
    logic        is_empty;
    logic [4:0]  entries;
  } rsp_t;

  // Finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic done;
    rsp_t rsp;
  } seq_rsp_t;

endpackage

/* design/evq_chan_if.sv */
`timescale 1ns / 1ps

interface evq_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

/* design/evq_ram.sv */
`timescale 1ns / 1ps

module evq_ram #(
  parameter int WIDTH = evq_pkg::ENTRY_W,
  parameter int DEPTH = evq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/evq_seq.sv */
`timescale 1ns / 1ps

module evq_seq #(
  parameter int DEPTH = evq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  evq_pkg::cmd_t                   cmd_data,
  output logic                            cmd_ready,
  input  logic                            out_free,
  output evq_pkg::seq_rsp_t               fin,
  output logic                            ram_we,
  output logic [$clog2(DEPTH)-1:0]        ram_waddr,
  output logic [evq_pkg::ENTRY_W-1:0]     ram_wdata,
  output logic [$clog2(DEPTH)-1:0]        ram_raddr,
  input  logic [evq_pkg::ENTRY_W-1:0]     ram_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  evq_pkg::state_t state, state_next;

  logic [IW-1:0]               rd_idx;
  logic [IW-1:0]               wr_idx;
  logic [IW-1:0]               scan_ptr;
  logic [CW-1:0]               count;
  logic [CW-1:0]               iss_cnt;
  logic [CW-1:0]               cmp_cnt;
  logic [evq_pkg::ENTRY_W-1:0] last_taken;
  logic [7:0]                  key;
  evq_pkg::rsp_t               res;
  evq_pkg::rsp_t               res_init;

  logic accept;
  logic full;
  logic empty;
  logic hit;
  logic last_cmp;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    ring_next = (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
  endfunction

  assign accept   = cmd_valid && cmd_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign hit      = (ram_rdata[7:0] == key);
  assign last_cmp = ((cmp_cnt + CW'(1)) == count);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      evq_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_data.operation == evq_pkg::OP_POP && !empty) begin
            state_next = evq_pkg::ST_FETCH;
          end else if (cmd_data.operation == evq_pkg::OP_SEARCH && !empty) begin
            state_next = evq_pkg::ST_SCAN;
          end else begin
            state_next = evq_pkg::ST_DONE;
          end
        end
      end
      evq_pkg::ST_FETCH: begin
        state_next = evq_pkg::ST_DONE;
      end
      evq_pkg::ST_SCAN: begin
        if (hit || last_cmp) begin
          state_next = evq_pkg::ST_DONE;
        end
      end
      evq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = evq_pkg::ST_IDLE;
        end
      end
      default: state_next = evq_pkg::ST_IDLE;
    endcase
  end

  // Handshake, memory port and result outputs
  always_comb begin
    cmd_ready = (state == evq_pkg::ST_IDLE) && !rst;
    ram_we    = cmd_ready && cmd_valid &&
                (cmd_data.operation == evq_pkg::OP_PUSH) && !full;
    ram_waddr = wr_idx;
    ram_wdata = {cmd_data.item_ref, cmd_data.item_kind, cmd_data.store_id};
    ram_raddr = (state == evq_pkg::ST_SCAN) ? scan_ptr : rd_idx;
    fin.done  = (state == evq_pkg::ST_DONE);
    fin.rsp   = res;
    fin.rsp.is_empty = empty;
    fin.rsp.entries  = 5'(count);
  end

  // Result fields known as soon as the command is taken
  always_comb begin
    res_init            = '0;
    res_init.dropped    = (cmd_data.operation == evq_pkg::OP_PUSH) && full;
    res_init.took_event = (cmd_data.operation == evq_pkg::OP_POP) && !empty;
    if (cmd_data.operation == evq_pkg::OP_REREAD) begin
      res_init.out_ref      = last_taken[31:16];
      res_init.out_kind     = last_taken[15:8];
      res_init.out_store_id = last_taken[7:0];
    end
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= evq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring pointers, fill count and last taken event
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      wr_idx     <= '0;
      count      <= '0;
      iss_cnt    <= '0;
      cmp_cnt    <= '0;
      last_taken <= '0;
    end else begin
      if (accept) begin
        unique case (cmd_data.operation)
          evq_pkg::OP_PUSH: begin
            if (!full) begin
              wr_idx <= ring_next(wr_idx);
              count  <= count + CW'(1);
            end
          end
          evq_pkg::OP_POP: begin
            if (!empty) begin
              rd_idx <= ring_next(rd_idx);
              count  <= count - CW'(1);
            end
          end
          evq_pkg::OP_SEARCH: begin
            iss_cnt <= CW'(1);
            cmp_cnt <= '0;
          end
          evq_pkg::OP_REREAD: begin
          end
          default: begin
          end
        endcase
      end
      if (state == evq_pkg::ST_FETCH) begin
        last_taken <= ram_rdata;
      end
      if (state == evq_pkg::ST_SCAN) begin
        if (iss_cnt < count) begin
          iss_cnt <= iss_cnt + CW'(1);
        end
        cmp_cnt <= cmp_cnt + CW'(1);
      end
    end
  end

  // Result payload and scan address
  always_ff @(posedge clk) begin
    if (accept) begin
      res      <= res_init;
      key      <= cmd_data.store_id;
      scan_ptr <= ring_next(rd_idx);
    end
    if (state == evq_pkg::ST_FETCH) begin
      res.out_ref      <= ram_rdata[31:16];
      res.out_kind     <= ram_rdata[15:8];
      res.out_store_id <= ram_rdata[7:0];
    end
    if (state == evq_pkg::ST_SCAN) begin
      if (iss_cnt < count) begin
        scan_ptr <= ring_next(scan_ptr);
      end
      if (hit) begin
        res.id_found <= 1'b1;
      end
    end
  end

  // Expected write slot from read slot and fill count
  logic [SW-1:0] ring_sum;
  logic [SW-1:0] ring_pos;

  always_comb begin
    ring_sum = SW'(rd_idx) + SW'(count);
    ring_pos = (ring_sum >= SW'(DEPTH)) ? ring_sum - SW'(DEPTH) : ring_sum;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    wr_idx == IW'(ring_pos))
    else $error("write slot out of step with read slot and count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == evq_pkg::ST_SCAN) |-> (cmp_cnt < count && iss_cnt > cmp_cnt))
    else $error("search runs past the queued entries");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_data.operation == evq_pkg::OP_POP && !empty)
      |=> (count == $past(count) - CW'(1)) && (state == evq_pkg::ST_FETCH))
    else $error("pop did not remove one entry");

endmodule

/* design/event_fifo_with_id_search.sv */
// Channel  Role    Beat payload
// -------  ------  ---------------------------------------------------------
// cmd      sink    operation, item_ref, item_kind, store_id
// rsp      source  out_ref, out_kind, out_store_id, took_event, id_found,
//                  dropped, is_empty, entries
//
// One command at a time; cmd_ready is high only while the sequencer is idle.
// Push and reread go straight to the done state; pop first does one registered
// RAM read (not when the queue is empty), search compares n entries (up to
// the fill count, DEPTH at most, ending at the first hit), one per cycle
// through the single id comparator behind the RAM port.
// Synchronous active-high reset empties the queue and clears the last event.
// A result waits in the output register; the next command is taken meanwhile,
// and the sequencer holds its finished result until that register frees up.
`timescale 1ns / 1ps

module event_fifo_with_id_search #(
  parameter int DEPTH = evq_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  evq_chan_if.sink   cmd,
  evq_chan_if.source rsp
);

  localparam int IW = $clog2(DEPTH);

  evq_pkg::seq_rsp_t           fin;
  logic                        out_free;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [evq_pkg::ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]               ram_raddr;
  logic [evq_pkg::ENTRY_W-1:0] ram_rdata;
  logic                        rsp_valid;
  evq_pkg::rsp_t               rsp_data;

  evq_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd.valid),
    .cmd_data (cmd.data),
    .cmd_ready(cmd.ready),
    .out_free (out_free),
    .fin      (fin),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  evq_ram #(
    .WIDTH(evq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !rsp_valid || rsp.ready;

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin.done && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.done && out_free) begin
      rsp_data <= fin.rsp;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import evq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  // One entry of the command backlog; a drain entry holds the sender back
  // until every result already owed has come back
  typedef struct {
    logic drain;
    cmd_t cmd;
  } backlog_t;

  logic clk = 1'b0;
  logic rst;

  evq_chan_if #(.payload_t(cmd_t)) cmd_if ();
  evq_chan_if #(.payload_t(rsp_t)) rsp_if ();

  event_fifo_with_id_search u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if.sink),
    .rsp (rsp_if.source)
  );

  always #5 clk = ~clk;

  backlog_t    cmd_backlog[$];
  rsp_t        owed_results[$];
  int unsigned cmds_queued   = 0;
  int unsigned cmds_accepted = 0;
  int unsigned results_done  = 0;
  int unsigned mismatches    = 0;
  logic [11:0] cycle_no      = '0;

  // Shadow copy of the event ring
  logic [15:0] ring_ref  [DEPTH];
  logic [7:0]  ring_kind [DEPTH];
  logic [7:0]  ring_id   [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  int unsigned ring_fill = 0;
  logic [31:0] last_taken = '0;

  // Tallies for the closing summary
  int unsigned n_push = 0, n_take = 0, n_search = 0, n_reread = 0;
  int unsigned n_drop = 0, n_hit = 0, n_empty_pop = 0, fill_peak = 0;

  // Apply one command to the shadow ring and return the result it owes
  function automatic rsp_t apply_cmd(cmd_t c);
    rsp_t        r;
    int unsigned i;
    r = '0;
    case (c.operation)
      OP_PUSH: begin
        n_push++;
        if (ring_fill >= DEPTH) begin
          r.dropped = 1'b1;
          n_drop++;
        end else begin
          ring_ref[ring_tail]  = c.item_ref;
          ring_kind[ring_tail] = c.item_kind;
          ring_id[ring_tail]   = c.store_id;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_fill++;
          if (ring_fill > fill_peak) fill_peak = ring_fill;
        end
      end
      OP_POP: begin
        if (ring_fill != 0) begin
          r.out_ref      = ring_ref[ring_head];
          r.out_kind     = ring_kind[ring_head];
          r.out_store_id = ring_id[ring_head];
          r.took_event   = 1'b1;
          last_taken = {r.out_ref, r.out_kind, r.out_store_id};
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
          n_take++;
        end else begin
          n_empty_pop++;
        end
      end
      OP_SEARCH: begin
        n_search++;
        for (i = 0; i < ring_fill; i++) begin
          if (ring_id[(ring_head + i) % DEPTH] == c.store_id) r.id_found = 1'b1;
        end
        if (r.id_found) n_hit++;
      end
      default: begin
        n_reread++;
        {r.out_ref, r.out_kind, r.out_store_id} = last_taken;
      end
    endcase
    r.is_empty = (ring_fill == 0);
    r.entries  = 5'(ring_fill);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(rsp_t got, rsp_t want);
    if (got.out_ref !== want.out_ref)
      report_mismatch("out_ref", got.out_ref, want.out_ref);
    if (got.out_kind !== want.out_kind)
      report_mismatch("out_kind", got.out_kind, want.out_kind);
    if (got.out_store_id !== want.out_store_id)
      report_mismatch("out_store_id", got.out_store_id, want.out_store_id);
    if (got.took_event !== want.took_event)
      report_mismatch("took_event", got.took_event, want.took_event);
    if (got.id_found !== want.id_found)
      report_mismatch("id_found", got.id_found, want.id_found);
    if (got.dropped !== want.dropped)
      report_mismatch("dropped", got.dropped, want.dropped);
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", got.is_empty, want.is_empty);
    if (got.entries !== want.entries)
      report_mismatch("entries", got.entries, want.entries);
  endtask

  task automatic queue_cmd(op_t op, logic [15:0] rf, logic [7:0] kd, logic [7:0] id);
    backlog_t b;
    b.drain         = 1'b0;
    b.cmd.operation = op;
    b.cmd.item_ref  = rf;
    b.cmd.item_kind = kd;
    b.cmd.store_id  = id;
    cmd_backlog.push_back(b);
    cmds_queued++;
  endtask

  // Mostly no gap, some short ones, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A quarter of the time, while cycle_no[9:8] is zero, neither side picks new idle gaps
  function automatic logic calm_window();
    return cycle_no[9:8] == 2'b00;
  endfunction

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1'b1;
  end

  // Command driver: offer backlog beats, hold each until taken
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    backlog_t nxt;
    if (rst) begin
      cmd_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        owed_results.push_back(apply_cmd(cmd_if.data));
        cmds_accepted++;
      end
      if (cmd_if.valid && !cmd_if.ready) begin
        // hold the current beat
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_if.valid <= 1'b0;
      end else begin
        // release a drain point once everything owed has come back
        while (cmd_backlog.size() > 0 && cmd_backlog[0].drain &&
               cmds_accepted == results_done)
          void'(cmd_backlog.pop_front());
        if (cmd_backlog.size() > 0 && !cmd_backlog[0].drain) begin
          nxt = cmd_backlog.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.data  <= nxt.cmd;
          send_gap = calm_window() ? 0 : pick_idle();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat against the oldest owed result
  int unsigned recv_gap   = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result beat", rsp_if.data, 0);
        end else begin
          want = owed_results.pop_front();
          check_result(rsp_if.data, want);
        end
        results_done <= results_done + 1;
      end
      // long hold-offs let the block fill up and stall its command side
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (holds_done < 2 && results_done >= (holds_done == 0 ? 80 : 300)) begin
        hold_left = 120;
        holds_done++;
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else if (!calm_window() && $urandom_range(0, 3) == 0) begin
        recv_gap = pick_idle();
        rsp_if.ready <= (recv_gap == 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end while (quiet < STALL_LIMIT);
    $display("[%0t] no beat moved for %0d cycles, %0d of %0d results in",
             $time, STALL_LIMIT, results_done, cmds_queued);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned blk, k, r, mode;
    logic [7:0]  id;
    op_t         op;
    backlog_t    pause;

    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rsp_if.ready = 1'b0;
    pause.drain  = 1'b1;
    pause.cmd    = '0;

    // Directed: reread and pop before anything is queued, search empty queue
    queue_cmd(OP_REREAD, 16'h1234, 8'h56, 8'h78);
    queue_cmd(OP_POP,    16'hFFFF, 8'hFF, 8'hFF);
    queue_cmd(OP_SEARCH, 16'h0000, 8'h00, 8'h00);
    // Field extremes, hit and miss searches, pop and reread
    queue_cmd(OP_PUSH,   16'hFFFF, 8'hFF, 8'hFF);
    queue_cmd(OP_PUSH,   16'h0000, 8'h00, 8'h00);
    queue_cmd(OP_SEARCH, 16'hFFFF, 8'hFF, 8'hFF);
    queue_cmd(OP_SEARCH, 16'h0000, 8'h00, 8'h5A);
    queue_cmd(OP_POP,    16'h0000, 8'h00, 8'h00);
    queue_cmd(OP_REREAD, 16'h0000, 8'h00, 8'h00);
    // Fill to the brim, push into a full queue, search the far end
    for (k = 0; k < 15; k++)
      queue_cmd(OP_PUSH, 16'(k * 16'h1111 + 16'h0101), 8'(k), 8'(8'hA0 + k));
    queue_cmd(OP_PUSH,   16'hBEEF, 8'h01, 8'h77);
    queue_cmd(OP_SEARCH, 16'h0000, 8'h00, 8'hAE);
    queue_cmd(OP_SEARCH, 16'h0000, 8'h00, 8'h77);
    cmd_backlog.push_back(pause);

    // Random: bursts that lean towards filling, draining or neither
    for (blk = 0; blk < 14; blk++) begin
      mode = $urandom_range(0, 2);
      for (k = 0; k < 30; k++) begin
        r = $urandom_range(0, 99);
        if (mode == 0)
          op = (r < 60) ? OP_PUSH : (r < 75) ? OP_POP : (r < 92) ? OP_SEARCH : OP_REREAD;
        else if (mode == 1)
          op = (r < 20) ? OP_PUSH : (r < 70) ? OP_POP : (r < 90) ? OP_SEARCH : OP_REREAD;
        else
          op = (r < 35) ? OP_PUSH : (r < 65) ? OP_POP : (r < 90) ? OP_SEARCH : OP_REREAD;
        // keep ids in a small pool half the time so searches hit
        id = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        queue_cmd(op, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), id);
      end
      if (blk == 6) cmd_backlog.push_back(pause);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (!(cmds_accepted == cmds_queued && results_done == cmds_queued))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_results.size() != 0)
      report_mismatch("results never returned", 0, owed_results.size());

    $display("Covered %0d commands: %0d pushes (%0d dropped), %0d pops (%0d on empty),",
             cmds_queued, n_push, n_drop, n_take + n_empty_pop, n_empty_pop);
    $display("  %0d searches (%0d hits), %0d rereads, peak fill %0d; %0d mismatches",
             n_search, n_hit, n_reread, fill_peak, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
